>>> hw/rtl/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_HEX2   = 3'd3,
        MODE_HEX3   = 3'd4,
        MODE_HEX4   = 3'd5
    } mode_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_ESCAPE    = 3'd1;
    localparam logic [2:0] ERR_PREMATURE = 3'd2;
    localparam logic [2:0] ERR_HEX       = 3'd3;
    localparam logic [2:0] ERR_SURROGATE = 3'd4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_CR  = 8'h0D;

    localparam logic [7:0] PRINT_LOW  = 8'h1F;
    localparam logic [7:0] PRINT_HIGH = 8'h80;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] hex_acc;
        logic        high_pending;
        logic        dropping;
    } parse_state_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic [2:0]  error_code;
        logic        string_end;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        mode:         MODE_NORMAL,
        hex_acc:      16'h0000,
        high_pending: 1'b0,
        dropping:     1'b0
    };

    // Bit 4 set flags a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h41 + 8'd10)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h61 + 8'd10)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/json_string_unescape.sv
// Top level of the streaming JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

// Streaming JSON string unescaper. One escaped byte enters per cycle while
// in_stall is low, with in_last on the final byte of a string; each byte yields
// zero or one result that carries a 16-bit UTF-16 code unit or an error code,
// with string_end set on the final result of the string. The sustained rate is
// one byte per clock while out_stall stays low: the parse state updates through
// combinational decode logic, and a two-entry result buffer (output register
// plus skid register) lets input continue after out_stall rises until the skid
// register fills. in_stall is a registered signal.
module json_string_unescape (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      code_unit,
    output logic             unit_valid,
    output logic [2:0]       error_code,
    output logic             string_end
);

    jsu_pkg::parse_state_t state_reg;
    jsu_pkg::parse_state_t state_next;
    jsu_pkg::result_t      dec_result;
    logic                  dec_valid;

    jsu_pkg::result_t      out_reg;
    logic                  out_valid_reg;
    jsu_pkg::result_t      skid_reg;
    logic                  skid_valid_reg;

    logic                  in_take;
    logic                  out_take;

    assign in_take  = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    jsu_decode u_decode (
        .state        (state_reg),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .state_next   (state_next),
        .result       (dec_result),
        .result_valid (dec_valid)
    );

    // Advance the parse state on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= jsu_pkg::STATE_RESET;
        end else if (in_take) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || out_take) begin
            out_valid_reg <= in_take && dec_valid;
        end else if (in_take && dec_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || out_take) begin
            out_reg <= dec_result;
        end else begin
            skid_reg <= dec_result;
        end
    end

    assign in_stall   = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign code_unit  = out_reg.code_unit;
    assign unit_valid = out_reg.unit_valid;
    assign error_code = out_reg.error_code;
    assign string_end = out_reg.string_end;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_unit_or_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.unit_valid && out_reg.error_code != jsu_pkg::ERR_NONE))
        else $error("result carries both a code unit and an error");

    a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.error_code != jsu_pkg::ERR_NONE) |-> out_reg.string_end)
        else $error("error result without string_end");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_last) |=> (state_reg == jsu_pkg::STATE_RESET))
        else $error("parse state not cleared after the final byte");

endmodule

`default_nettype wire

>>> hw/rtl/jsu_decode.sv
// Per-byte decode: next parse state and the result for one input byte.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
    input  wire jsu_pkg::parse_state_t state,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    output jsu_pkg::parse_state_t      state_next,
    output jsu_pkg::result_t           result,
    output logic                       result_valid
);

    logic        have;
    logic [15:0] unit;
    logic [2:0]  err;
    logic [4:0]  digit;
    logic        is_high;
    logic        is_low;
    jsu_pkg::parse_state_t work;

    always_comb
    begin
        work         = state;
        have         = 1'b0;
        unit         = 16'h0000;
        err          = jsu_pkg::ERR_NONE;
        digit        = jsu_pkg::hex_value(in_byte);
        is_high      = 1'b0;
        is_low       = 1'b0;
        state_next   = state;
        result       = '0;
        result_valid = 1'b0;

        if (state.dropping) begin
            if (in_last) begin
                state_next = jsu_pkg::STATE_RESET;
            end
        end else begin
            unique case (state.mode)
                jsu_pkg::MODE_ESCAPE:
                begin
                    work.mode = jsu_pkg::MODE_NORMAL;
                    have      = 1'b1;
                    unique case (in_byte)
                        jsu_pkg::CH_BACKSLASH: unit = {8'h00, jsu_pkg::CH_BACKSLASH};
                        jsu_pkg::CH_QUOTE:     unit = {8'h00, jsu_pkg::CH_QUOTE};
                        jsu_pkg::CH_T:         unit = {8'h00, jsu_pkg::CTRL_TAB};
                        jsu_pkg::CH_B:         unit = {8'h00, jsu_pkg::CTRL_BS};
                        jsu_pkg::CH_F:         unit = {8'h00, jsu_pkg::CTRL_FF};
                        jsu_pkg::CH_N:         unit = {8'h00, jsu_pkg::CTRL_LF};
                        jsu_pkg::CH_R:         unit = {8'h00, jsu_pkg::CTRL_CR};
                        jsu_pkg::CH_U:
                        begin
                            have         = 1'b0;
                            work.mode    = jsu_pkg::MODE_HEX1;
                            work.hex_acc = 16'h0000;
                        end
                        default:
                        begin
                            if (in_byte > jsu_pkg::PRINT_LOW && in_byte < jsu_pkg::PRINT_HIGH)
                            begin
                                unit = {8'h00, in_byte};
                            end else begin
                                have = 1'b0;
                                err  = jsu_pkg::ERR_ESCAPE;
                            end
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2,
                jsu_pkg::MODE_HEX3, jsu_pkg::MODE_HEX4:
                begin
                    if (digit[4]) begin
                        err = jsu_pkg::ERR_HEX;
                    end else begin
                        work.hex_acc = {state.hex_acc[11:0], digit[3:0]};
                        if (state.mode == jsu_pkg::MODE_HEX4) begin
                            unit      = work.hex_acc;
                            have      = 1'b1;
                            work.mode = jsu_pkg::MODE_NORMAL;
                        end else begin
                            work.mode = jsu_pkg::mode_t'(state.mode + 3'd1);
                        end
                    end
                end
                default:
                begin
                    work.mode = jsu_pkg::MODE_NORMAL;
                    if (in_byte == jsu_pkg::CH_BACKSLASH) begin
                        work.mode = jsu_pkg::MODE_ESCAPE;
                    end else begin
                        unit = {8'h00, in_byte};
                        have = 1'b1;
                    end
                end
            endcase

            is_high = (unit[15:10] == jsu_pkg::SURR_HIGH_TAG);
            is_low  = (unit[15:10] == jsu_pkg::SURR_LOW_TAG);

            if (err == jsu_pkg::ERR_NONE && have) begin
                priority if (state.high_pending) begin
                    if (is_low) begin
                        work.high_pending = 1'b0;
                    end else begin
                        err = jsu_pkg::ERR_SURROGATE;
                    end
                end else if (is_low) begin
                    err = jsu_pkg::ERR_SURROGATE;
                end else if (is_high) begin
                    work.high_pending = 1'b1;
                end
            end

            if (err == jsu_pkg::ERR_NONE && in_last) begin
                priority if (work.mode == jsu_pkg::MODE_ESCAPE) begin
                    err = jsu_pkg::ERR_PREMATURE;
                end else if (work.mode == jsu_pkg::MODE_HEX1
                          || work.mode == jsu_pkg::MODE_HEX2
                          || work.mode == jsu_pkg::MODE_HEX3
                          || work.mode == jsu_pkg::MODE_HEX4) begin
                    err = jsu_pkg::ERR_HEX;
                end else if (work.high_pending) begin
                    err = jsu_pkg::ERR_SURROGATE;
                end
            end

            if (err != jsu_pkg::ERR_NONE) begin
                result.error_code   = err;
                result.string_end   = 1'b1;
                result_valid        = 1'b1;
                state_next          = jsu_pkg::STATE_RESET;
                state_next.dropping = !in_last;
            end else if (have) begin
                result.code_unit  = unit;
                result.unit_valid = 1'b1;
                result.string_end = in_last;
                result_valid      = 1'b1;
                state_next        = in_last ? jsu_pkg::STATE_RESET : work;
            end else begin
                state_next = work;
            end
        end
    end

endmodule

`default_nettype wire
